// File: hdl/rau_pkg.sv
// Shared types and codes for the rational arithmetic unit.
package rau_pkg;

  localparam int OPERAND_WIDTH_DEF = 32;
  localparam int RES_W             = 64;

  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_SUB = 3'd1;
  localparam logic [2:0] KIND_MUL = 3'd2;
  localparam logic [2:0] KIND_DIV = 3'd3;
  localparam logic [2:0] KIND_CMP = 3'd4;

  localparam logic [1:0] ORD_LESS    = 2'd0;
  localparam logic [1:0] ORD_EQUAL   = 2'd1;
  localparam logic [1:0] ORD_GREATER = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_ZERO_DEN = 2'd1;
  localparam logic [1:0] STAT_DIV_ZERO = 2'd2;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_t;

  typedef struct packed {
    logic signed [63:0] res_num;
    logic [62:0]        res_den;
    logic [1:0]         order;
    logic [1:0]         status;
  } out_t;

  // Status of the reduction unit as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } red_st_t;

endpackage

// File: hdl/rau_red.sv
// Fraction reduction: binary gcd, then two restoring divisions by the gcd.
module rau_red (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [rau_pkg::RES_W-1:0] mag,
  input  logic [rau_pkg::RES_W-1:0] den,
  output rau_pkg::red_st_t        st,
  output logic [rau_pkg::RES_W-1:0] q_mag,
  output logic [rau_pkg::RES_W-1:0] q_den
);

  localparam int W    = rau_pkg::RES_W;
  localparam int CW   = $clog2(W);
  localparam int KW   = $clog2(W);

  typedef enum logic [2:0] {
    R_IDLE = 3'b001,
    R_GCD  = 3'b010,
    R_DIV  = 3'b100
  } rstate_t;

  rstate_t         state_r, state_nxt;
  logic [W-1:0]    x_r, y_r, mag_r, den_r, g_r, dvd_r, rem_r, q_mag_r, q_den_r;
  logic [KW-1:0]   k_r;
  logic [CW-1:0]   cnt_r;
  logic            sel_r, done_r;

  logic [W:0]      trial;
  logic            ge;
  logic [W-1:0]    rem_nxt, dvd_nxt;

  always_comb begin
    trial   = {rem_r, dvd_r[W-1]};
    ge      = trial >= {1'b0, g_r};
    rem_nxt = ge ? W'(trial - {1'b0, g_r}) : trial[W-1:0];
    dvd_nxt = {dvd_r[W-2:0], ge};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      R_IDLE:  if (start) state_nxt = R_GCD;
      R_GCD:   if (x_r == y_r) state_nxt = R_DIV;
      R_DIV:   if (sel_r && (cnt_r == CW'(W - 1))) state_nxt = R_IDLE;
      default: state_nxt = R_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == R_DIV) && sel_r && (cnt_r == CW'(W - 1));
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      R_IDLE: begin
        if (start) begin
          x_r   <= mag;
          y_r   <= den;
          mag_r <= mag;
          den_r <= den;
          k_r   <= '0;
        end
      end
      R_GCD: begin
        if (x_r == y_r) begin
          g_r   <= x_r << k_r;
          dvd_r <= mag_r;
          rem_r <= '0;
          cnt_r <= '0;
          sel_r <= 1'b0;
        end else if (!x_r[0] && !y_r[0]) begin
          x_r <= x_r >> 1;
          y_r <= y_r >> 1;
          k_r <= k_r + 1'b1;
        end else if (!x_r[0]) begin
          x_r <= x_r >> 1;
        end else if (!y_r[0]) begin
          y_r <= y_r >> 1;
        end else if (x_r > y_r) begin
          x_r <= (x_r - y_r) >> 1;
        end else begin
          y_r <= (y_r - x_r) >> 1;
        end
      end
      R_DIV: begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W - 1)) begin
          // first pass done: latch quotient, restart on the denominator
          if (!sel_r) begin
            q_mag_r <= dvd_nxt;
            dvd_r   <= den_r;
            rem_r   <= '0;
            sel_r   <= 1'b1;
          end else begin
            q_den_r <= dvd_nxt;
          end
        end else begin
          dvd_r <= dvd_nxt;
          rem_r <= rem_nxt;
        end
      end
      default: ;
    endcase
  end

  assign st.busy = (state_r != R_IDLE);
  assign st.done = done_r;
  assign q_mag   = q_mag_r;
  assign q_den   = q_den_r;

endmodule

// File: hdl/rational_arith_unit.sv
// Top level of the rational arithmetic unit: sequencer, shared multiplier, output register.
//
// One input transfer carries an operation code and two fractions; one result
// transfer follows with the reduced numerator, positive denominator (zero on an error), compare
// order and status. Operands use the low OPERAND_WIDTH bits, sign extended.
// in_stall is high from the accepted transfer until the result has been moved
// into the output register, so items are worked on one at a time.
// An error item goes from the accepted transfer straight to the final state; compare and a
// zero result skip the reduction; other operations also run the binary gcd steps and the two
// 64-step restoring divisions by the gcd. The single OPERAND_WIDTH x OPERAND_WIDTH multiplier
// is used three times per item that is not an error.
// A result waits in the output register while out_stall is high; the next
// item is accepted meanwhile and holds in its final state until the register
// frees up. Synchronous reset clears the sequencer and the output valid.
module rational_arith_unit #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rau_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output rau_pkg::out_t out_data
);

  localparam int W  = OPERAND_WIDTH;
  localparam int PW = 2 * W;
  localparam int RW = rau_pkg::RES_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_COMB = 5'b00100,
    S_RED  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  function automatic logic [W-1:0] mag_of(input logic [31:0] raw);
    logic [W-1:0] v;
    v = raw[W-1:0];
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  state_t            state_r;
  logic [2:0]        kind_r;
  logic [W-1:0]      an_r, ad_r, bn_r, bd_r;
  logic              sa_r, sb_r, neg_r;
  logic [1:0]        cnt_r;
  logic [2*W-1:0]    prod_r;
  logic [RW-1:0]     p0_r, p1_r, p2_r;
  logic signed [RW-1:0] res_num_r;
  logic [62:0]       res_den_r;
  logic [1:0]        order_r, status_r;
  logic              out_valid_r;
  rau_pkg::out_t     out_data_r;

  logic              accept, out_free;
  logic              ad_zero, bd_zero, bn_zero, single;
  logic [W-1:0]      opx, opy;

  logic              red_start;
  rau_pkg::red_st_t  red_st;
  logic [RW-1:0]     q_mag, q_den;

  logic              s2;
  logic [RW-1:0]     sum, diff_ab, diff_ba, mag_c;
  logic              neg_c;
  logic signed [RW-1:0] va, vb;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign ad_zero = (in_data.a_den[W-1:0] == '0);
  assign bd_zero = (in_data.b_den[W-1:0] == '0);
  assign bn_zero = (in_data.b_num[W-1:0] == '0);
  assign single  = (in_data.kind > rau_pkg::KIND_CMP);

  // multiplier operand select per product slot
  always_comb begin
    opx = an_r;
    opy = bd_r;
    case (kind_r)
      rau_pkg::KIND_ADD, rau_pkg::KIND_SUB, rau_pkg::KIND_CMP: begin
        case (cnt_r)
          2'd0:    begin opx = an_r; opy = bd_r; end
          2'd1:    begin opx = bn_r; opy = ad_r; end
          default: begin opx = ad_r; opy = bd_r; end
        endcase
      end
      rau_pkg::KIND_MUL: begin
        if (cnt_r == 2'd0) begin
          opx = an_r; opy = bn_r;
        end else begin
          opx = ad_r; opy = bd_r;
        end
      end
      rau_pkg::KIND_DIV: begin
        if (cnt_r == 2'd0) begin
          opx = an_r; opy = bd_r;
        end else begin
          opx = ad_r; opy = bn_r;
        end
      end
      default: begin
        opx = (cnt_r == 2'd0) ? an_r : ad_r;
        opy = W'(1);
      end
    endcase
  end

  // combine products into a signed magnitude and compare
  always_comb begin
    s2      = sb_r ^ (kind_r == rau_pkg::KIND_SUB);
    sum     = p0_r + p1_r;
    diff_ab = p0_r - p1_r;
    diff_ba = p1_r - p0_r;
    va      = sa_r ? -$signed(p0_r) : $signed(p0_r);
    vb      = sb_r ? -$signed(p1_r) : $signed(p1_r);
    case (kind_r)
      rau_pkg::KIND_ADD, rau_pkg::KIND_SUB: begin
        if (sa_r == s2) begin
          mag_c = sum;     neg_c = sa_r;
        end else if (p0_r >= p1_r) begin
          mag_c = diff_ab; neg_c = sa_r;
        end else begin
          mag_c = diff_ba; neg_c = s2;
        end
      end
      rau_pkg::KIND_MUL, rau_pkg::KIND_DIV: begin
        mag_c = p0_r; neg_c = sa_r ^ sb_r;
      end
      default: begin
        mag_c = p0_r; neg_c = sa_r;
      end
    endcase
  end

  assign red_start = (state_r == S_COMB) && (kind_r != rau_pkg::KIND_CMP) && (mag_c != '0);

  rau_red u_red (
    .clk   (clk),
    .rst_n (rst_n),
    .start (red_start),
    .mag   (mag_c),
    .den   (p2_r),
    .st    (red_st),
    .q_mag (q_mag),
    .q_den (q_den)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_FIN) && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (ad_zero || (!single && bd_zero)
                || ((in_data.kind == rau_pkg::KIND_DIV) && bn_zero)) state_r <= S_FIN;
            else state_r <= S_MUL;
          end
        end
        S_MUL:   if (cnt_r == 2'd3) state_r <= S_COMB;
        S_COMB:  state_r <= red_start ? S_RED : S_FIN;
        S_RED:   if (red_st.done) state_r <= S_FIN;
        S_FIN:   if (out_free) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        kind_r    <= in_data.kind;
        an_r      <= mag_of(in_data.a_num);
        ad_r      <= mag_of(in_data.a_den);
        bn_r      <= mag_of(in_data.b_num);
        bd_r      <= mag_of(in_data.b_den);
        sa_r      <= in_data.a_num[W-1] ^ in_data.a_den[W-1];
        sb_r      <= in_data.b_num[W-1] ^ in_data.b_den[W-1];
        cnt_r     <= '0;
        res_num_r <= '0;
        res_den_r <= '0;
        order_r   <= rau_pkg::ORD_EQUAL;
        if (ad_zero || (!single && bd_zero)) status_r <= rau_pkg::STAT_ZERO_DEN;
        else if ((in_data.kind == rau_pkg::KIND_DIV) && bn_zero)
          status_r <= rau_pkg::STAT_DIV_ZERO;
        else status_r <= rau_pkg::STAT_OK;
      end
      S_MUL: begin
        // store the product of the previous cycle, launch the next one
        case (cnt_r)
          2'd1:    p0_r <= RW'(prod_r);
          2'd2:    p1_r <= RW'(prod_r);
          2'd3:    p2_r <= RW'(prod_r);
          default: ;
        endcase
        prod_r <= PW'(opx) * PW'(opy);
        cnt_r  <= cnt_r + 1'b1;
      end
      S_COMB: begin
        neg_r     <= neg_c;
        res_num_r <= '0;
        res_den_r <= 63'd1;
        if (kind_r == rau_pkg::KIND_CMP) begin
          if (va < vb)       order_r <= rau_pkg::ORD_LESS;
          else if (va == vb) order_r <= rau_pkg::ORD_EQUAL;
          else               order_r <= rau_pkg::ORD_GREATER;
        end
      end
      S_RED: begin
        if (red_st.done) begin
          res_num_r <= neg_r ? -$signed(q_mag) : $signed(q_mag);
          res_den_r <= q_den[62:0];
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_data_r.res_num <= res_num_r;
          out_data_r.res_den <= res_den_r;
          out_data_r.order   <= order_r;
          out_data_r.status  <= status_r;
        end
      end
      default: ;
    endcase
  end

  a_red_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !red_st.busy)
    else $error("reduction unit busy while sequencer idle");

  a_red_done: assert property (@(posedge clk) disable iff (!rst_n)
    red_st.done |-> (state_r == S_RED))
    else $error("reduction done outside reduce state");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status != rau_pkg::STAT_OK))
      |-> ((out_data_r.res_den == '0) && (out_data_r.res_num == '0)))
    else $error("error result carries nonzero fraction");

  a_ok_den: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == rau_pkg::STAT_OK)) |-> (out_data_r.res_den != '0))
    else $error("valid result with zero denominator");

endmodule
